@@ rtl/lsmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmp_pkg
// Shared types, constants and tables of the lidar scan to map points unit.
// ----------------------------------------------------------------------------
package lsmp_pkg;

    // default sizes handed to the top level
    localparam int RANGE_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 24;

    // angle resolution kept by the cordic; at 32 bits no low bits are masked off
    localparam int          ANGLE_BITS = 32;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // cordic datapath width, Q2.30 plus headroom
    localparam int CW = 34;

    // starting x of the rotation, 0.60725293 in Q2.30
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in binary turns
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // configuration register indexes
    localparam int              CFG_IDX_W        = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_XX       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_XY       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_YX       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_YY       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION  = 8'd7;
    localparam int              CFG_DATA_W       = 64;

    // identity element of the rotation, 1.0 in Q2.30
    localparam logic signed [31:0] ROT_ONE = 32'sd1073741824;

    // control that travels with each word down the cell chain
    typedef struct packed {
        logic valid;
        logic flip;
    } t_cell_ctl;

    // cordic vector and residual angle
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic_vec;

endpackage

@@ rtl/lsmp_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmp interfaces
// Sample, point and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// one range sample word
interface lsmp_sample_if import lsmp_pkg::*; #(
    parameter int RANGE_BITS = RANGE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_sample;
    logic                  sample_finite;
    logic                  first_of_scan;

    modport source (output valid, range_sample, sample_finite, first_of_scan, input ready);
    modport sink   (input valid, range_sample, sample_finite, first_of_scan, output ready);
endinterface

// one map point word
interface lsmp_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;

    modport source (output valid, map_x, map_y, input ready);
    modport sink   (input valid, map_x, map_y, output ready);
endinterface

// register write word
interface lsmp_cfg_if import lsmp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lsmp_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmp_cordic_cell
// One rotation-mode cordic iteration, registered, passing range and flags on.
// ----------------------------------------------------------------------------
module lsmp_cordic_cell import lsmp_pkg::*; #(
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int STAGE      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_cell_ctl             i_ctl,
    input  t_cordic_vec           i_vec,
    input  logic [RANGE_BITS-1:0] i_range,
    output t_cell_ctl             o_ctl,
    output t_cordic_vec           o_vec,
    output logic [RANGE_BITS-1:0] o_range
);

    t_cell_ctl             r_ctl;
    t_cordic_vec           r_vec;
    logic [RANGE_BITS-1:0] r_range;
    t_cordic_vec           n_vec;
    logic signed [CW-1:0]  w_dx;
    logic signed [CW-1:0]  w_dy;
    logic signed [CW-1:0]  w_t;

    // shifted cross terms (floor shift) and this stage's angle
    assign w_dx = $signed(i_vec.y) >>> STAGE;
    assign w_dy = $signed(i_vec.x) >>> STAGE;
    assign w_t  = $signed(CW'(ATAN_TURNS[STAGE]));

    // rotate toward zero residual angle
    always_comb begin
        if (!i_vec.z[CW-1]) begin
            n_vec.x = i_vec.x - w_dx;
            n_vec.y = i_vec.y + w_dy;
            n_vec.z = i_vec.z - w_t;
        end else begin
            n_vec.x = i_vec.x + w_dx;
            n_vec.y = i_vec.y - w_dy;
            n_vec.z = i_vec.z + w_t;
        end
    end

    // cell register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl   <= i_ctl;
            r_vec   <= n_vec;
            r_range <= i_range;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_vec   = r_vec;
    assign o_range = r_range;

endmodule

@@ rtl/lsmp_point_xform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmp_point_xform
// Scales cos/sin by range, applies rotation and translation, saturates.
// ----------------------------------------------------------------------------
module lsmp_point_xform import lsmp_pkg::*; #(
    parameter int RANGE_BITS = RANGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_cell_ctl             i_ctl,
    input  t_cordic_vec           i_vec,
    input  logic [RANGE_BITS-1:0] i_range,
    input  logic signed [31:0]    i_rot_xx,
    input  logic signed [31:0]    i_rot_xy,
    input  logic signed [31:0]    i_rot_yx,
    input  logic signed [31:0]    i_rot_yy,
    input  logic [63:0]           i_translation,
    output logic                  o_valid,
    output logic signed [31:0]    o_map_x,
    output logic signed [31:0]    o_map_y
);

    // product widths through the stages
    localparam int PW  = RANGE_BITS + 1 + CW;
    localparam int XLW = PW - 30;
    localparam int PR  = 32 + XLW;
    localparam int SW  = PR + 1;
    localparam int HW  = SW - 30;
    localparam int VW  = ((HW > 32) ? HW : 32) + 1;

    localparam logic signed [PW-1:0] HALF_P = {{(PW-30){1'b0}}, 1'b1, 29'd0};
    localparam logic signed [SW-1:0] HALF_S = {{(SW-30){1'b0}}, 1'b1, 29'd0};
    localparam logic signed [VW-1:0] SAT_HI = {{(VW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO = {{(VW-31){1'b1}}, {31{1'b0}}};

    logic                  r_p1_valid;
    logic                  r_p2_valid;
    logic                  r_p3_valid;
    logic                  r_out_valid;
    logic signed [PW-1:0]  r_px;
    logic signed [PW-1:0]  r_py;
    logic signed [XLW-1:0] r_xl;
    logic signed [XLW-1:0] r_yl;
    logic signed [PR-1:0]  r_pxx;
    logic signed [PR-1:0]  r_pxy;
    logic signed [PR-1:0]  r_pyx;
    logic signed [PR-1:0]  r_pyy;
    logic signed [31:0]    r_map_x;
    logic signed [31:0]    r_map_y;

    logic signed [CW-1:0]  w_c;
    logic signed [CW-1:0]  w_s;
    logic signed [PW-1:0]  n_px;
    logic signed [PW-1:0]  n_py;
    logic signed [PW-1:0]  w_rx;
    logic signed [PW-1:0]  w_ry;
    logic signed [PR-1:0]  n_pxx;
    logic signed [PR-1:0]  n_pxy;
    logic signed [PR-1:0]  n_pyx;
    logic signed [PR-1:0]  n_pyy;
    logic signed [SW-1:0]  w_sx;
    logic signed [SW-1:0]  w_sy;
    logic signed [VW-1:0]  w_vx;
    logic signed [VW-1:0]  w_vy;
    logic signed [31:0]    n_map_x;
    logic signed [31:0]    n_map_y;

    // undo the half-turn fold and scale by range
    assign w_c  = i_ctl.flip ? -i_vec.x : i_vec.x;
    assign w_s  = i_ctl.flip ? -i_vec.y : i_vec.y;
    assign n_px = $signed({1'b0, i_range}) * w_c;
    assign n_py = $signed({1'b0, i_range}) * w_s;

    // round to Q16.16 local point
    assign w_rx = r_px + HALF_P;
    assign w_ry = r_py + HALF_P;

    // rotation products
    assign n_pxx = i_rot_xx * r_xl;
    assign n_pxy = i_rot_xy * r_yl;
    assign n_pyx = i_rot_yx * r_xl;
    assign n_pyy = i_rot_yy * r_yl;

    // sum, round, translate
    assign w_sx = SW'(r_pxx) + SW'(r_pxy) + HALF_S;
    assign w_sy = SW'(r_pyx) + SW'(r_pyy) + HALF_S;
    assign w_vx = VW'($signed(w_sx[SW-1:30])) + VW'($signed(i_translation[31:0]));
    assign w_vy = VW'($signed(w_sy[SW-1:30])) + VW'($signed(i_translation[63:32]));

    // saturate to signed 32 bits
    always_comb begin
        priority if (w_vx > SAT_HI) begin
            n_map_x = 32'sh7FFFFFFF;
        end else if (w_vx < SAT_LO) begin
            n_map_x = 32'sh80000000;
        end else begin
            n_map_x = w_vx[31:0];
        end
        priority if (w_vy > SAT_HI) begin
            n_map_y = 32'sh7FFFFFFF;
        end else if (w_vy < SAT_LO) begin
            n_map_y = 32'sh80000000;
        end else begin
            n_map_y = w_vy[31:0];
        end
    end

    // stage registers, all advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid  <= i_ctl.valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
            r_px        <= n_px;
            r_py        <= n_py;
            r_xl        <= w_rx[PW-1:30];
            r_yl        <= w_ry[PW-1:30];
            r_pxx       <= n_pxx;
            r_pxy       <= n_pxy;
            r_pyx       <= n_pyx;
            r_pyy       <= n_pyy;
            r_map_x     <= n_map_x;
            r_map_y     <= n_map_y;
        end
    end

    assign o_valid = r_out_valid;
    assign o_map_x = r_map_x;
    assign o_map_y = r_map_y;

endmodule

@@ rtl/lidar_scan_to_map_points_unit.sv @@
`timescale 1ns / 1ps
// A sample passes the chain entry register, the cordic cell chain and the product stages before its point is valid.
// Throughput: one sample per cycle; the cordic cell chain and the product stages
// all advance together, held only while the output word waits to be taken.
// Dropped samples leave a bubble and produce no point; the angle still advances.
// Reset (synchronous, active low) restores the register defaults, clears the
// angle accumulator to zero and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
// lidar_scan_to_map_points_unit
// Beam angle tracking, range window, cordic chain and map-frame transform.
// ----------------------------------------------------------------------------
module lidar_scan_to_map_points_unit import lsmp_pkg::*; #(
    parameter int RANGE_BITS    = RANGE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsmp_sample_if.sink   i_sample,
    lsmp_cfg_if.sink      i_cfg,
    lsmp_point_if.source  o_point
);

    // configuration registers
    logic [2*RANGE_BITS-1:0] r_range_window;
    logic [31:0]             r_angle_start;
    logic [31:0]             r_angle_step;
    logic signed [31:0]      r_rot_xx;
    logic signed [31:0]      r_rot_xy;
    logic signed [31:0]      r_rot_yx;
    logic signed [31:0]      r_rot_yy;
    logic [63:0]             r_translation;

    // angle accumulator and chain entry
    logic [31:0]             r_angle;
    t_cell_ctl               r_s0_ctl;
    t_cordic_vec             r_s0_vec;
    logic [RANGE_BITS-1:0]   r_s0_range;

    logic                    w_en;
    logic                    w_accept;
    logic                    w_keep;
    logic                    w_out_valid;
    logic [31:0]             w_angle_sel;
    logic [31:0]             w_masked;
    logic                    w_flip;
    logic [31:0]             w_folded;
    logic [RANGE_BITS-1:0]   w_rmin;
    logic [RANGE_BITS-1:0]   w_rmax;

    t_cell_ctl               w_ctl   [CORDIC_STAGES+1];
    t_cordic_vec             w_vec   [CORDIC_STAGES+1];
    logic [RANGE_BITS-1:0]   w_range [CORDIC_STAGES+1];

    // whole pipeline moves unless the output word is stalled
    assign w_en           = !w_out_valid || o_point.ready;
    assign i_sample.ready = w_en;
    assign w_accept       = i_sample.valid && w_en;
    assign i_cfg.ready    = 1'b1;

    // range window test
    assign w_rmin = r_range_window[RANGE_BITS-1:0];
    assign w_rmax = r_range_window[2*RANGE_BITS-1:RANGE_BITS];
    assign w_keep = i_sample.sample_finite
                 && (i_sample.range_sample >= w_rmin)
                 && (i_sample.range_sample <= w_rmax);

    // angle for this sample, folded into the right half-plane
    assign w_angle_sel = i_sample.first_of_scan ? r_angle_start : r_angle;
    assign w_masked    = w_angle_sel & ANGLE_MASK;
    assign w_flip      = w_masked[31] ^ w_masked[30];
    assign w_folded    = {w_masked[31] ^ w_flip, w_masked[30:0]};

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_window <= {{RANGE_BITS{1'b1}}, {RANGE_BITS{1'b0}}};
            r_angle_start  <= '0;
            r_angle_step   <= '0;
            r_rot_xx       <= ROT_ONE;
            r_rot_xy       <= '0;
            r_rot_yx       <= '0;
            r_rot_yy       <= ROT_ONE;
            r_translation  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RANGE_WINDOW: r_range_window <= i_cfg.data[2*RANGE_BITS-1:0];
                REG_ANGLE_START:  r_angle_start  <= i_cfg.data[31:0];
                REG_ANGLE_STEP:   r_angle_step   <= i_cfg.data[31:0];
                REG_ROT_XX:       r_rot_xx       <= i_cfg.data[31:0];
                REG_ROT_XY:       r_rot_xy       <= i_cfg.data[31:0];
                REG_ROT_YX:       r_rot_yx       <= i_cfg.data[31:0];
                REG_ROT_YY:       r_rot_yy       <= i_cfg.data[31:0];
                REG_TRANSLATION:  r_translation  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // angle tracking and chain entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle        <= '0;
            r_s0_ctl.valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_angle <= w_angle_sel + r_angle_step;
            end
            if (w_en) begin
                r_s0_ctl.valid <= w_accept && w_keep;
                r_s0_ctl.flip  <= w_flip;
                r_s0_vec.x     <= CORDIC_GAIN;
                r_s0_vec.y     <= '0;
                r_s0_vec.z     <= CW'($signed(w_folded));
                r_s0_range     <= i_sample.range_sample;
            end
        end
    end

    assign w_ctl[0]   = r_s0_ctl;
    assign w_vec[0]   = r_s0_vec;
    assign w_range[0] = r_s0_range;

    // cordic cell chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        lsmp_cordic_cell #(
            .RANGE_BITS (RANGE_BITS),
            .STAGE      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_vec   (w_vec[g]),
            .i_range (w_range[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_vec   (w_vec[g+1]),
            .o_range (w_range[g+1])
        );
    end

    // scale, rotate, translate, output word
    lsmp_point_xform #(
        .RANGE_BITS (RANGE_BITS)
    ) u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_ctl         (w_ctl[CORDIC_STAGES]),
        .i_vec         (w_vec[CORDIC_STAGES]),
        .i_range       (w_range[CORDIC_STAGES]),
        .i_rot_xx      (r_rot_xx),
        .i_rot_xy      (r_rot_xy),
        .i_rot_yx      (r_rot_yx),
        .i_rot_yy      (r_rot_yy),
        .i_translation (r_translation),
        .o_valid       (w_out_valid),
        .o_map_x       (o_point.map_x),
        .o_map_y       (o_point.map_y)
    );

    assign o_point.valid = w_out_valid;

`ifndef ASSERT_OFF
    // a non-finite sample never enters the chain
    a_drop_nonfinite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_sample.sample_finite |=> !r_s0_ctl.valid)
        else $error("non-finite sample entered the cordic chain");

    // scan start reloads the accumulator, already advanced by one step
    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_sample.first_of_scan
        |=> r_angle == $past(r_angle_start) + $past(r_angle_step))
        else $error("angle accumulator not restarted at scan start");

    // a stalled pipeline holds its entry stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s0_ctl) && $stable(r_angle))
        else $error("pipeline moved while output stalled");
`endif

endmodule
